// ----- rtl/sra_pkg.sv -----
// ----------------------------------------------------------------------------
// sra_pkg
// Shared widths, limits, operation codes and payload types of the step rate
// accumulator.
// ----------------------------------------------------------------------------
package sra_pkg;

   localparam int FRACTION_BITS_DEFAULT = 9;

   localparam int OP_W       = 3;
   localparam int RATE_W     = 16;
   localparam int ACC_W      = RATE_W + 1;
   localparam int BATCH_W    = 8;
   localparam int RECENT_W   = 14;
   localparam int SESSION_W  = 17;
   localparam int TOTAL_W    = 24;
   localparam int CREDIT_W   = 14;
   localparam int DAY_W      = 14;
   localparam int SECONDS_W  = 16;
   localparam int PROGRESS_W = 16;
   localparam int PACING_W   = 10;
   localparam int CSR_W      = 8;

   localparam logic [OP_W-1:0] OP_DETECT   = 3'd0;
   localparam logic [OP_W-1:0] OP_TICK     = 3'd1;
   localparam logic [OP_W-1:0] OP_ROLLOVER = 3'd2;
   localparam logic [OP_W-1:0] OP_SECOND   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

   localparam logic [RECENT_W-1:0]   RECENT_MAX   = 14'd9999;
   localparam logic [SESSION_W-1:0]  SESSION_MAX  = 17'd99999;
   localparam logic [TOTAL_W-1:0]    TOTAL_MAX    = 24'd9999999;
   localparam logic [CREDIT_W-1:0]   CREDIT_MAX   = 14'd9999;
   localparam logic [DAY_W-1:0]      DAY_MAX      = 14'd9999;
   localparam logic [SECONDS_W-1:0]  SECONDS_MAX  = 16'hFFFF;
   localparam logic [PROGRESS_W-1:0] PROGRESS_MAX = 16'hFFFF;
   localparam logic [PACING_W-1:0]   PACING_MAX   = 10'd1023;
   localparam logic [PACING_W-1:0]   PACING_STEP  = 10'h40;
   localparam logic [PACING_W-1:0]   PACING_START = 10'd32;
   localparam logic [BATCH_W-1:0]    BATCH_MAX    = 8'd255;
   localparam logic [CSR_W-1:0]      CREDIT_RESET = 8'd20;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [RATE_W-1:0] step_rate;
      logic [RATE_W-1:0] pending_rate;
      logic              clear_totals;
   } req_type;

   typedef struct packed {
      logic [BATCH_W-1:0]   batch_size;
      logic [RECENT_W-1:0]  recent_steps;
      logic [SESSION_W-1:0] session_count;
      logic [TOTAL_W-1:0]   total_count;
      logic [CREDIT_W-1:0]  credits;
      logic                 timer_reload;
      logic [DAY_W-1:0]     day_count;
      logic [SECONDS_W-1:0] second_ticks;
   } rsp_type;

   typedef struct packed {
      logic [RECENT_W-1:0]   recent;
      logic [SESSION_W-1:0]  session;
      logic [TOTAL_W-1:0]    total;
      logic [PROGRESS_W-1:0] progress;
      logic [CREDIT_W-1:0]   credits;
   } credit_state_type;

endpackage

// ----- rtl/sra_req_if.sv -----
// ----------------------------------------------------------------------------
// sra_req_if
// Request channel: one operation per transfer.
// ----------------------------------------------------------------------------
interface sra_req_if;
   import sra_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [RATE_W-1:0]   step_rate;
   logic [RATE_W-1:0]   pending_rate;
   logic                clear_totals;

   modport source (output valid, op, step_rate, pending_rate, clear_totals, input ready);
   modport sink   (input valid, op, step_rate, pending_rate, clear_totals, output ready);
endinterface

// ----- rtl/sra_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sra_rsp_if
// Response channel: counter snapshot after each operation.
// ----------------------------------------------------------------------------
interface sra_rsp_if;
   import sra_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BATCH_W-1:0]   batch_size;
   logic [RECENT_W-1:0]  recent_steps;
   logic [SESSION_W-1:0] session_count;
   logic [TOTAL_W-1:0]   total_count;
   logic [CREDIT_W-1:0]  credits;
   logic                 timer_reload;
   logic [DAY_W-1:0]     day_count;
   logic [SECONDS_W-1:0] second_ticks;

   modport source (output valid, batch_size, recent_steps, session_count, total_count,
                   credits, timer_reload, day_count, second_ticks, input ready);
   modport sink   (input valid, batch_size, recent_steps, session_count, total_count,
                   credits, timer_reload, day_count, second_ticks, output ready);
endinterface

// ----- rtl/step_rate_accumulator.sv -----
// ----------------------------------------------------------------------------
// step_rate_accumulator
// Pedometer step accounting: batches, pacing, saturating counters, credits.
//
// req_ch takes one operation per transfer (detect, pacing tick, day rollover,
// second tick, clear); rsp_ch returns one counter snapshot per operation, in
// order. csr_wr_en/csr_wr_data write credit_steps; the user must write it only
// while the block is idle, the block itself does not enforce this. A request is
// held in the input register, then the core applies it to the state and loads
// the result register, which drives the response. The state update is a single
// pass of saturating adds, so one request is taken every cycle while the
// receiver does not stall. Reset clears all counters and the pipeline and sets
// credit_steps to 20. When the receiver stalls, the result register holds its
// response, the input register fills with one more request, and then
// req_ch.ready drops until the response is taken.
// ----------------------------------------------------------------------------
module step_rate_accumulator #(
   parameter int FRACTION_BITS = sra_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [sra_pkg::CSR_W-1:0]   csr_wr_data,
   sra_req_if.sink                     req_ch,
   sra_rsp_if.source                   rsp_ch
);
   import sra_pkg::*;

   logic    item_valid;
   req_type item;
   rsp_type result;
   logic    can_load;
   logic    advance;

   assign advance = item_valid && can_load;

   sra_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   sra_core #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (advance),
      .item        (item),
      .result      (result)
   );

   sra_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ----- rtl/sra_in_reg.sv -----
// ----------------------------------------------------------------------------
// sra_in_reg
// Input register: holds one accepted request until the core takes it.
// ----------------------------------------------------------------------------
module sra_in_reg (
   input  logic              clock,
   input  logic              reset,
   sra_req_if.sink           req_ch,
   input  logic              advance,
   output logic              item_valid,
   output sra_pkg::req_type  item
);
   import sra_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign req_ch.ready = !valid_ff || advance;
   assign valid_in     = req_ch.valid || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         data_ff.op           <= req_ch.op;
         data_ff.step_rate    <= req_ch.step_rate;
         data_ff.pending_rate <= req_ch.pending_rate;
         data_ff.clear_totals <= req_ch.clear_totals;
      end
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

// ----- rtl/sra_credit.sv -----
// ----------------------------------------------------------------------------
// sra_credit
// Step crediting: saturating counter adds and credit earning.
// ----------------------------------------------------------------------------
module sra_credit (
   input  logic                            en,
   input  logic [sra_pkg::BATCH_W-1:0]     steps,
   input  logic [sra_pkg::CSR_W-1:0]       credit_steps,
   input  sra_pkg::credit_state_type       st_i,
   output sra_pkg::credit_state_type       st_o
);
   import sra_pkg::*;

   logic [RECENT_W:0]   recent_sum;
   logic [SESSION_W:0]  session_sum;
   logic [TOTAL_W:0]    total_sum;
   logic [PROGRESS_W:0] progress_sum;
   logic [PROGRESS_W-1:0] progress_sat;

   always_comb begin
      recent_sum   = (RECENT_W + 1)'(st_i.recent) + (RECENT_W + 1)'(steps);
      session_sum  = (SESSION_W + 1)'(st_i.session) + (SESSION_W + 1)'(steps);
      total_sum    = (TOTAL_W + 1)'(st_i.total) + (TOTAL_W + 1)'(steps);
      progress_sum = (PROGRESS_W + 1)'(st_i.progress) + (PROGRESS_W + 1)'(steps);
      progress_sat = (progress_sum > (PROGRESS_W + 1)'(PROGRESS_MAX)) ?
                     PROGRESS_MAX : progress_sum[PROGRESS_W-1:0];
      st_o = st_i;
      if (en) begin
         st_o.recent  = (recent_sum > (RECENT_W + 1)'(RECENT_MAX)) ?
                        RECENT_MAX : recent_sum[RECENT_W-1:0];
         st_o.session = (session_sum > (SESSION_W + 1)'(SESSION_MAX)) ?
                        SESSION_MAX : session_sum[SESSION_W-1:0];
         st_o.total   = (total_sum > (TOTAL_W + 1)'(TOTAL_MAX)) ?
                        TOTAL_MAX : total_sum[TOTAL_W-1:0];
         st_o.progress = progress_sat;
         if (progress_sat >= PROGRESS_W'(credit_steps)) begin
            st_o.progress = progress_sat - PROGRESS_W'(credit_steps);
            if (st_i.credits < CREDIT_MAX) begin
               st_o.credits = st_i.credits + CREDIT_W'(1);
            end
         end
      end
   end

endmodule

// ----- rtl/sra_core.sv -----
// ----------------------------------------------------------------------------
// sra_core
// Step accounting state and the per-operation update logic.
// ----------------------------------------------------------------------------
module sra_core #(
   parameter int FRACTION_BITS = sra_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [sra_pkg::CSR_W-1:0]    csr_wr_data,
   input  logic                         fire,
   input  sra_pkg::req_type             item,
   output sra_pkg::rsp_type             result
);
   import sra_pkg::*;

   logic [CSR_W-1:0]         credit_steps_ff;
   logic [FRACTION_BITS-1:0] rem_ff,      rem_in;
   logic [BATCH_W-1:0]       batch_ff,    batch_in;
   logic [BATCH_W-1:0]       released_ff, released_in;
   logic [PACING_W-1:0]      pacing_ff,   pacing_in;
   credit_state_type         cstate_ff,   cstate_in;
   logic [DAY_W-1:0]         day_ff,      day_in;
   logic [SECONDS_W-1:0]     seconds_ff,  seconds_in;

   credit_state_type         cstate_cr;
   logic [ACC_W-1:0]         acc_pend, whole_pend, acc_rate, whole_rate;
   logic [BATCH_W-1:0]       pend_steps, rate_batch, rel_next, credit_n;
   logic [FRACTION_BITS-1:0] rem_mid;
   logic [PACING_W:0]        pace_sum;
   logic [PACING_W-1:0]      pace_sat;
   logic [BATCH_W:0]         rel_inc;
   logic                     pace_fire, tick_active, detect_active, credit_en, reload;

   always_comb begin
      acc_pend   = ACC_W'(rem_ff) + ACC_W'(item.pending_rate);
      whole_pend = acc_pend >> FRACTION_BITS;
      pend_steps = (whole_pend > ACC_W'(BATCH_MAX)) ? BATCH_MAX : whole_pend[BATCH_W-1:0];
      rem_mid    = (item.pending_rate != '0) ? acc_pend[FRACTION_BITS-1:0] : rem_ff;
      acc_rate   = ACC_W'(rem_mid) + ACC_W'(item.step_rate);
      whole_rate = acc_rate >> FRACTION_BITS;
      rate_batch = (whole_rate > ACC_W'(BATCH_MAX)) ? BATCH_MAX : whole_rate[BATCH_W-1:0];

      pace_sum    = (PACING_W + 1)'(pacing_ff) + (PACING_W + 1)'(batch_ff);
      pace_sat    = (pace_sum > (PACING_W + 1)'(PACING_MAX)) ?
                    PACING_MAX : pace_sum[PACING_W-1:0];
      pace_fire   = pace_sat > PACING_STEP;
      tick_active = released_ff != batch_ff;
      rel_inc     = (BATCH_W + 1)'(released_ff) + (BATCH_W + 1)'(1);
      rel_next    = (rel_inc > (BATCH_W + 1)'(batch_ff)) ? batch_ff : rel_inc[BATCH_W-1:0];

      detect_active = (item.op == OP_DETECT) && (item.step_rate != '0);
      credit_en     = (detect_active && (item.pending_rate != '0)) ||
                      ((item.op == OP_TICK) && tick_active && pace_fire);
      credit_n      = (item.op == OP_DETECT) ? pend_steps : BATCH_W'(1);
   end

   sra_credit u_credit (
      .en           (credit_en),
      .steps        (credit_n),
      .credit_steps (credit_steps_ff),
      .st_i         (cstate_ff),
      .st_o         (cstate_cr)
   );

   always_comb begin
      rem_in      = rem_ff;
      batch_in    = batch_ff;
      released_in = released_ff;
      pacing_in   = pacing_ff;
      cstate_in   = cstate_cr;
      day_in      = day_ff;
      seconds_in  = seconds_ff;
      reload      = 1'b0;
      unique case (item.op)
         OP_DETECT: begin
            if (detect_active) begin
               rem_in      = acc_rate[FRACTION_BITS-1:0];
               batch_in    = rate_batch;
               released_in = '0;
               pacing_in   = PACING_START;
               reload      = rate_batch != '0;
            end
         end
         OP_TICK: begin
            if (tick_active) begin
               pacing_in = pace_sat;
               if (pace_fire) begin
                  released_in = rel_next;
                  pacing_in   = pace_sat - PACING_STEP;
               end
            end
         end
         OP_ROLLOVER: begin
            if (day_ff < DAY_MAX) begin
               day_in = day_ff + DAY_W'(1);
            end
            cstate_in.session = '0;
         end
         OP_SECOND: begin
            if (seconds_ff < SECONDS_MAX) begin
               seconds_in = seconds_ff + SECONDS_W'(1);
            end
         end
         OP_CLEAR: begin
            seconds_in         = '0;
            cstate_in.credits  = '0;
            cstate_in.progress = '0;
            if (item.clear_totals) begin
               cstate_in.total = '0;
               day_in          = '0;
            end
         end
         default: begin
         end
      endcase

      result.batch_size    = batch_in;
      result.recent_steps  = cstate_in.recent;
      result.session_count = cstate_in.session;
      result.total_count   = cstate_in.total;
      result.credits       = cstate_in.credits;
      result.timer_reload  = reload;
      result.day_count     = day_in;
      result.second_ticks  = seconds_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_steps_ff <= CREDIT_RESET;
         rem_ff          <= '0;
         batch_ff        <= '0;
         released_ff     <= '0;
         pacing_ff       <= '0;
         cstate_ff       <= '0;
         day_ff          <= '0;
         seconds_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            credit_steps_ff <= csr_wr_data;
         end
         if (fire) begin
            rem_ff      <= rem_in;
            batch_ff    <= batch_in;
            released_ff <= released_in;
            pacing_ff   <= pacing_in;
            cstate_ff   <= cstate_in;
            day_ff      <= day_in;
            seconds_ff  <= seconds_in;
         end
      end
   end

endmodule

// ----- rtl/sra_out_reg.sv -----
// ----------------------------------------------------------------------------
// sra_out_reg
// Result register: holds one response until the receiver takes it.
// ----------------------------------------------------------------------------
module sra_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  sra_pkg::rsp_type  result,
   output logic              can_load,
   sra_rsp_if.source         rsp_ch
);
   import sra_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign can_load = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.batch_size    = data_ff.batch_size;
   assign rsp_ch.recent_steps  = data_ff.recent_steps;
   assign rsp_ch.session_count = data_ff.session_count;
   assign rsp_ch.total_count   = data_ff.total_count;
   assign rsp_ch.credits       = data_ff.credits;
   assign rsp_ch.timer_reload  = data_ff.timer_reload;
   assign rsp_ch.day_count     = data_ff.day_count;
   assign rsp_ch.second_ticks  = data_ff.second_ticks;

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the step rate accumulator. A local predictor keeps
// its own copy of the remainder, batch, pacing and counter state, and builds
// the expected counter snapshot for every accepted request. The result
// process compares each returned snapshot field by field against the oldest
// one. The tests cover the directed edge values, pacing, credit_steps
// settings, random activity with undefined operation codes under three idling
// patterns, a long receiver stall and saturation of the recent step counter.
// ----------------------------------------------------------------------------
module tb_top;
   import sra_pkg::*;

   localparam int          FRAC          = FRACTION_BITS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned DRAIN_CYCLES  = 10;
   localparam int unsigned MAX_REPORTS   = 40;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   sra_req_if req_bus ();
   sra_rsp_if rsp_bus ();

   step_rate_accumulator dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [CSR_W-1:0]      steps_per_credit = CREDIT_RESET;
   logic [FRAC-1:0]       rate_frac        = '0;
   logic [BATCH_W-1:0]    batch_now        = '0;
   logic [BATCH_W-1:0]    batch_released   = '0;
   logic [PACING_W-1:0]   pace_acc         = '0;
   logic [RECENT_W-1:0]   recent_cnt       = '0;
   logic [SESSION_W-1:0]  session_cnt      = '0;
   logic [TOTAL_W-1:0]    total_cnt        = '0;
   logic [PROGRESS_W-1:0] credit_prog      = '0;
   logic [CREDIT_W-1:0]   credit_cnt       = '0;
   logic [DAY_W-1:0]      day_cnt          = '0;
   logic [SECONDS_W-1:0]  sec_cnt          = '0;

   rsp_type     expected_snapshots[$];
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_left     = 0;
   bit          hold_start    = 1'b0;

   function automatic int unsigned sat_add(input int unsigned a, input int unsigned b,
                                           input int unsigned ceiling);
      int unsigned s;
      s = a + b;
      return (s > ceiling) ? ceiling : s;
   endfunction

   function automatic void add_steps(input int unsigned n);
      recent_cnt  = RECENT_W'(sat_add(recent_cnt, n, RECENT_MAX));
      session_cnt = SESSION_W'(sat_add(session_cnt, n, SESSION_MAX));
      total_cnt   = TOTAL_W'(sat_add(total_cnt, n, TOTAL_MAX));
      credit_prog = PROGRESS_W'(sat_add(credit_prog, n, PROGRESS_MAX));
      if (credit_prog >= steps_per_credit) begin
         credit_prog = credit_prog - steps_per_credit;
         credit_cnt  = CREDIT_W'(sat_add(credit_cnt, 1, CREDIT_MAX));
      end
   endfunction

   // adds a rate into the fraction remainder, returns the clamped whole part
   function automatic logic [BATCH_W-1:0] take_whole(input logic [RATE_W-1:0] rate);
      logic [ACC_W-1:0] acc;
      acc       = ACC_W'(rate_frac) + ACC_W'(rate);
      rate_frac = acc[FRAC-1:0];
      return ((acc >> FRAC) > BATCH_MAX) ? BATCH_MAX : BATCH_W'(acc >> FRAC);
   endfunction

   function automatic rsp_type advance_counters(input req_type r);
      rsp_type s;
      logic    reload;
      reload = 1'b0;
      case (r.op)
         OP_DETECT: begin
            if (r.step_rate != '0) begin
               if (r.pending_rate != '0) add_steps(take_whole(r.pending_rate));
               batch_now      = take_whole(r.step_rate);
               reload         = (batch_now != '0);
               batch_released = '0;
               pace_acc       = PACING_START;
            end
         end
         OP_TICK: begin
            if (batch_released != batch_now) begin
               pace_acc = PACING_W'(sat_add(pace_acc, batch_now, PACING_MAX));
               if (pace_acc > PACING_STEP) begin
                  add_steps(1);
                  if (batch_released < batch_now) batch_released = batch_released + 1'b1;
                  pace_acc = pace_acc - PACING_STEP;
               end
            end
         end
         OP_ROLLOVER: begin
            day_cnt     = DAY_W'(sat_add(day_cnt, 1, DAY_MAX));
            session_cnt = '0;
         end
         OP_SECOND: begin
            sec_cnt = SECONDS_W'(sat_add(sec_cnt, 1, SECONDS_MAX));
         end
         OP_CLEAR: begin
            if (r.clear_totals) begin
               total_cnt = '0;
               day_cnt   = '0;
            end
            sec_cnt     = '0;
            credit_cnt  = '0;
            credit_prog = '0;
         end
         default: ;
      endcase
      s.batch_size    = batch_now;
      s.recent_steps  = recent_cnt;
      s.session_count = session_cnt;
      s.total_count   = total_cnt;
      s.credits       = credit_cnt;
      s.timer_reload  = reload;
      s.day_count     = day_cnt;
      s.second_ticks  = sec_cnt;
      return s;
   endfunction

   task automatic send_op(input logic [OP_W-1:0] op, input logic [RATE_W-1:0] rate,
                          input logic [RATE_W-1:0] pend, input logic clr);
      req_type r;
      r.op           = op;
      r.step_rate    = rate;
      r.pending_rate = pend;
      r.clear_totals = clr;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= r.op;
      req_bus.step_rate    <= r.step_rate;
      req_bus.pending_rate <= r.pending_rate;
      req_bus.clear_totals <= r.clear_totals;
      do @(posedge clock); while (!req_bus.ready);
      expected_snapshots.push_back(advance_counters(r));
   endtask

   task automatic write_credit_steps(input logic [CSR_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (expected_snapshots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en        <= 1'b0;
      steps_per_credit  = value;
   endtask

   function automatic logic [RATE_W-1:0] random_rate();
      return $urandom_range(1) ? RATE_W'($urandom_range(1, 16'hFFFF))
                               : RATE_W'($urandom_range(1, 16'h0BFF));
   endfunction

   // mostly detect-then-tick sequences, with housekeeping ops and noise
   task automatic run_activity(input int unsigned n);
      int unsigned sent;
      int unsigned pick;
      int unsigned ticks;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_op(OP_DETECT, random_rate(),
                    $urandom_range(1) ? RATE_W'($urandom) : '0, 1'($urandom));
            ticks = $urandom_range(24);
            repeat (ticks) send_op(OP_TICK, RATE_W'($urandom), RATE_W'($urandom), 1'($urandom));
            sent += 1 + ticks;
         end else begin
            if (pick < 63)
               send_op(OP_ROLLOVER, RATE_W'($urandom), RATE_W'($urandom), 1'($urandom));
            else if (pick < 71)
               send_op(OP_SECOND, RATE_W'($urandom), RATE_W'($urandom), 1'($urandom));
            else if (pick < 77)
               send_op(OP_CLEAR, RATE_W'($urandom), RATE_W'($urandom), 1'($urandom));
            else if (pick < 85)
               send_op(OP_DETECT, '0, RATE_W'($urandom), 1'($urandom));
            else
               send_op(OP_W'($urandom_range(2**OP_W - 1)), RATE_W'($urandom),
                       RATE_W'($urandom), 1'($urandom));
            sent++;
         end
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 28;
      recv_idle_pct = 58;
      send_op(OP_DETECT, '0, 16'hFFFF, 1'b0);
      send_op(OP_DETECT, 16'h0300, '0, 1'b0);
      repeat (3) send_op(OP_TICK, '0, '0, 1'b0);
      send_op(OP_DETECT, 16'h00FF, '0, 1'b0);
      send_op(OP_TICK, '0, '0, 1'b0);
      send_op(OP_DETECT, 16'hFFFF, 16'hFFFF, 1'b0);
      send_op(OP_DETECT, 16'h0001, 16'h0001, 1'b0);
      repeat (2) send_op(OP_TICK, 16'hFFFF, 16'hFFFF, 1'b1);
      repeat (2) send_op(OP_SECOND, '0, '0, 1'b0);
      send_op(OP_ROLLOVER, '0, '0, 1'b0);
      send_op(OP_CLEAR, '0, '0, 1'b0);
      send_op(OP_DETECT, 16'hFFFF, '0, 1'b1);
      send_op(OP_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1);
      for (int k = OP_CLEAR + 1; k < 2**OP_W; k++)
         send_op(OP_W'(k), 16'hFFFF, 16'hFFFF, 1'b1);
      send_op(OP_DETECT, 16'h8000, 16'h7FFF, 1'b0);
   endtask

   // large batch drives the pacing accumulator into saturation, small one paces slowly
   task automatic test_pacing();
      send_op(OP_DETECT, 16'hFFFF, '0, 1'b0);
      repeat (130) send_op(OP_TICK, '0, '0, 1'b0);
      send_op(OP_DETECT, 16'h0200, '0, 1'b0);
      repeat (40) send_op(OP_TICK, '0, '0, 1'b0);
   endtask

   task automatic test_config();
      logic [CSR_W-1:0] values[5];
      send_idle_pct = 58;
      recv_idle_pct = 28;
      values = '{8'd0, 8'd1, 8'd255, CREDIT_RESET, CSR_W'($urandom_range(2, 254))};
      foreach (values[i]) begin
         write_credit_steps(values[i]);
         run_activity(20);
      end
   endtask

   task automatic test_random();
      send_idle_pct = 28;
      recv_idle_pct = 58;
      write_credit_steps(CSR_W'($urandom_range(1, 255)));
      run_activity(80);
      send_idle_pct = 58;
      recv_idle_pct = 28;
      write_credit_steps(CSR_W'($urandom_range(1, 255)));
      run_activity(80);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_credit_steps(CSR_W'($urandom_range(1, 255)));
      run_activity(80);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_start    = 1'b1;
      run_activity(40);
   endtask

   // drive the recent counter to its ceiling, then clear from there
   task automatic test_saturation();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_credit_steps('0);
      repeat (80) send_op(OP_DETECT, 16'h0001, 16'hFFFF, 1'b0);
      repeat (4) send_op(OP_TICK, '0, '0, 1'b0);
      send_op(OP_CLEAR, '0, '0, 1'b0);
      repeat (3) send_op(OP_ROLLOVER, '0, '0, 1'b0);
      repeat (3) send_op(OP_SECOND, '0, '0, 1'b0);
      send_op(OP_CLEAR, '0, '0, 1'b1);
      send_op(OP_DETECT, 16'h0400, 16'h0400, 1'b0);
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   task automatic check_snapshot();
      rsp_type want;
      if (expected_snapshots.size() == 0) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result transfer, batch_size %0d", $time,
                     rsp_bus.batch_size);
         return;
      end
      want = expected_snapshots.pop_front();
      compare_field("batch_size", want.batch_size, rsp_bus.batch_size);
      compare_field("recent_steps", want.recent_steps, rsp_bus.recent_steps);
      compare_field("session_count", want.session_count, rsp_bus.session_count);
      compare_field("total_count", want.total_count, rsp_bus.total_count);
      compare_field("credits", want.credits, rsp_bus.credits);
      compare_field("timer_reload", want.timer_reload, rsp_bus.timer_reload);
      compare_field("day_count", want.day_count, rsp_bus.day_count);
      compare_field("second_ticks", want.second_ticks, rsp_bus.second_ticks);
   endtask

   // result side: check each transfer, then pick the next ready
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) check_snapshot();
         if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.op           <= OP_DETECT;
      req_bus.step_rate    <= '0;
      req_bus.pending_rate <= '0;
      req_bus.clear_totals <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_pacing();
      test_config();
      test_random();
      test_backpressure();
      test_saturation();
      req_bus.valid <= 1'b0;
      while (expected_snapshots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
